// ===== rtl/bicubic_image_resize_core_defines.svh =====
// Assertion macros shared by the resampler RTL
`ifndef BICUBIC_IMAGE_RESIZE_CORE_DEFINES_SVH
`define BICUBIC_IMAGE_RESIZE_CORE_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define BIR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle
`define BIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bir_pkg.sv =====
package bir_pkg;

    // Datapath word of the fit unit
    localparam int FIT_W = 32;
    typedef logic signed [FIT_W-1:0] t_word;

    // Fit steps: three Horner products, then the divide by six
    localparam logic [1:0] STEP_C3  = 2'd0;
    localparam logic [1:0] STEP_C2  = 2'd1;
    localparam logic [1:0] STEP_C1  = 2'd2;
    localparam logic [1:0] STEP_DIV = 2'd3;

    // Reciprocal of three: floor(u/3) = (u * DIV3_MUL) >> DIV3_SHIFT for u < 2^26
    localparam logic signed [26:0] DIV3_MUL   = 27'sd44739243;
    localparam int                 DIV3_SHIFT = 27;
    localparam t_word              DIV_BIAS   = 32'sd16777216;
    localparam t_word              DIV_BIAS3  = 32'sd50331648;

    // Output saturation limits
    localparam t_word OUT_MAX = 32'sd131071;
    localparam t_word OUT_MIN = -32'sd131072;

    // Configuration register indexes
    localparam logic [1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_X_STEP     = 2'd2;
    localparam logic [1:0] CFG_Y_STEP     = 2'd3;

    // Control from the sequencer to the fit unit
    typedef struct packed {
        logic       en;
        logic [1:0] step;
    } t_fit_ctl;

endpackage

// ===== rtl/bir_ram.sv =====
module bir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write or read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bir_fit.sv =====
module bir_fit import bir_pkg::*; (
    input  logic     i_clk,
    input  t_fit_ctl i_ctl,
    input  t_word    i_p [4],
    input  logic [15:0] i_t,
    output t_word    o_result
);

    t_word               d0, d2, d3, c1, c2, c3;
    t_word               opa, addend, n_acc, rnd, half, uval;
    logic signed [26:0]  opb;
    logic signed [58:0]  prod;
    logic signed [58:0]  prod_rnd;
    t_word               r_acc;

    // Fit coefficients from the four samples
    always_comb begin
        d0 = i_p[0] - i_p[1];
        d2 = i_p[2] - i_p[1];
        d3 = i_p[3] - i_p[1];
        c1 = -(d0 <<< 1) + (d2 <<< 2) + (d2 <<< 1) - d3;
        c2 = (d0 <<< 1) + d0 + (d2 <<< 1) + d2;
        c3 = -d0 - (d2 <<< 1) - d2 + d3;
    end

    // Select operands of the shared multiplier
    always_comb begin
        half   = (r_acc + 32'sd3) >>> 1;
        uval   = half + DIV_BIAS3;
        opa    = r_acc;
        opb    = $signed({11'b0, i_t});
        addend = '0;
        case (i_ctl.step)
            STEP_C3:  begin opa = c3; addend = c2; end
            STEP_C2:  begin addend = c1; end
            STEP_C1:  begin addend = '0; end
            STEP_DIV: begin opa = uval; opb = DIV3_MUL; end
            default:  begin addend = '0; end
        endcase
        prod     = opa * opb;
        prod_rnd = (prod + 59'sd32768) >>> 16;
        rnd      = prod_rnd[FIT_W-1:0];
        if (i_ctl.step == STEP_DIV) begin
            n_acc = i_p[1] + t_word'(prod >>> DIV3_SHIFT) - DIV_BIAS;
        end else begin
            n_acc = rnd + addend;
        end
    end

    // Advance the accumulator
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_result = r_acc;

endmodule

// ===== rtl/bicubic_image_resize_core.sv =====
// Sequence: a compute transaction runs from accept through mapping, sixteen image
// reads and five cubic fits to the output register, where the result turns valid.
// Only one compute is in flight: the single image RAM port and the one shared fit
// multiplier serve it until its result is loaded; a load is written when accepted.
// Reset: synchronous active-low; clears control state and loads the default
// config values, image memory content stays undefined until written.
`include "bicubic_image_resize_core_defines.svh"
module bicubic_image_resize_core import bir_pkg::*; #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_pixel_value,
    input  logic [7:0]  i_load_col,
    input  logic [7:0]  i_load_row,
    input  logic [11:0] i_dest_col,
    input  logic [11:0] i_dest_row,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [17:0] o_height_value,
    output logic        o_clipped,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_SRC_WIDTH);
    localparam int RW    = $clog2(MAX_SRC_HEIGHT);
    localparam int WW    = $clog2(MAX_SRC_WIDTH + 1);
    localparam int HW    = $clog2(MAX_SRC_HEIGHT + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAP  = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_FIT  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]   r_state;
    logic [8:0]   r_cfg_w, r_cfg_h;
    logic [23:0]  r_x_step, r_y_step;
    logic [11:0]  r_dcol, r_drow;
    logic [19:0]  r_xi, r_yi;
    logic [15:0]  r_tx, r_ty;
    logic [WW-1:0] r_w;
    logic [HW-1:0] r_h;
    logic [4:0]   r_cnt;
    logic [2:0]   r_fit;
    logic [2:0]   r_step;
    logic [7:0]   r_pix [16];
    t_word        r_curve [4];
    t_word        r_final;
    logic         r_out_valid;
    logic signed [17:0] r_out_value;
    logic         r_out_clip;

    logic         in_acc, load_we, out_load;
    logic [35:0]  px, py;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic signed [21:0] col_s, row_s, wm1, hm1;
    logic [CW-1:0] col_c;
    logic [RW-1:0] row_c;
    logic [AW-1:0] ram_addr;
    logic [7:0]   ram_rdata;
    t_fit_ctl     fit_ctl;
    t_word        fit_p [4];
    logic [15:0]  fit_t;
    t_word        fit_res;

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && o_ready;
    assign load_we     = in_acc && !i_kind
                         && ({24'b0, i_load_col} < 32'(MAX_SRC_WIDTH))
                         && ({24'b0, i_load_row} < 32'(MAX_SRC_HEIGHT));
    assign out_load    = (r_state == ST_OUT) && (!r_out_valid || i_ready);

    // Map destination position into the source
    assign px = {24'b0, r_dcol} * {12'b0, r_x_step};
    assign py = {24'b0, r_drow} * {12'b0, r_y_step};

    // Clamp the size registers to the store
    always_comb begin
        if (r_cfg_w == 9'd0) begin
            w_eff = WW'(1);
        end else if (32'(r_cfg_w) > 32'(MAX_SRC_WIDTH)) begin
            w_eff = WW'(MAX_SRC_WIDTH);
        end else begin
            w_eff = WW'(r_cfg_w);
        end
        if (r_cfg_h == 9'd0) begin
            h_eff = HW'(1);
        end else if (32'(r_cfg_h) > 32'(MAX_SRC_HEIGHT)) begin
            h_eff = HW'(MAX_SRC_HEIGHT);
        end else begin
            h_eff = HW'(r_cfg_h);
        end
    end

    // Clamp the neighbourhood read address to the image
    always_comb begin
        wm1   = $signed(22'(r_w)) - 22'sd1;
        hm1   = $signed(22'(r_h)) - 22'sd1;
        col_s = $signed({2'b0, r_xi}) - 22'sd1 + $signed({20'b0, r_cnt[1:0]});
        row_s = $signed({2'b0, r_yi}) - 22'sd1 + $signed({20'b0, r_cnt[3:2]});
        if (col_s < 0) begin
            col_s = '0;
        end else if (col_s > wm1) begin
            col_s = wm1;
        end
        if (row_s < 0) begin
            row_s = '0;
        end else if (row_s > hm1) begin
            row_s = hm1;
        end
        col_c = CW'(col_s);
        row_c = RW'(row_s);
        if (r_state == ST_IDLE) begin
            ram_addr = AW'(AW'(RW'(i_load_row)) * AW'(MAX_SRC_WIDTH)) + AW'(CW'(i_load_col));
        end else begin
            ram_addr = AW'(AW'(row_c) * AW'(MAX_SRC_WIDTH)) + AW'(col_c);
        end
    end

    bir_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_image (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_addr  (ram_addr),
        .i_wdata (i_pixel_value),
        .o_rdata (ram_rdata)
    );

    // Feed the fit unit a pixel row or the column of curve values
    always_comb begin
        fit_ctl.en   = (r_state == ST_FIT) && (r_step != 3'd4);
        fit_ctl.step = r_step[1:0];
        for (int j = 0; j < 4; j++) begin
            if (r_fit == 3'd4) begin
                fit_p[j] = r_curve[j];
            end else begin
                fit_p[j] = $signed({16'b0, r_pix[{r_fit[1:0], 2'(j)}], 8'b0});
            end
        end
        fit_t = (r_fit == 3'd4) ? r_ty : r_tx;
    end

    bir_fit u_fit (
        .i_clk    (i_clk),
        .i_ctl    (fit_ctl),
        .i_p      (fit_p),
        .i_t      (fit_t),
        .o_result (fit_res)
    );

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w  <= 9'd256;
            r_cfg_h  <= 9'd256;
            r_x_step <= 24'd65536;
            r_y_step <= 24'd65536;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SRC_WIDTH:  r_cfg_w  <= i_cfg_data[8:0];
                CFG_SRC_HEIGHT: r_cfg_h  <= i_cfg_data[8:0];
                CFG_X_STEP:     r_x_step <= i_cfg_data;
                CFG_Y_STEP:     r_y_step <= i_cfg_data;
                default:        r_cfg_w  <= r_cfg_w;
            endcase
        end
    end

    // Sequence one compute transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_fit   <= '0;
            r_step  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_acc && i_kind) begin
                        r_state <= ST_MAP;
                    end
                end
                ST_MAP: begin
                    r_cnt   <= '0;
                    r_state <= ST_READ;
                end
                ST_READ: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd16) begin
                        r_fit   <= '0;
                        r_step  <= '0;
                        r_state <= ST_FIT;
                    end
                end
                ST_FIT: begin
                    if (r_step == 3'd4) begin
                        r_step <= '0;
                        r_fit  <= r_fit + 3'd1;
                        if (r_fit == 3'd4) begin
                            r_state <= ST_OUT;
                        end
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Capture mapping, pixels and fit results
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_dcol <= i_dest_col;
            r_drow <= i_dest_row;
        end
        if (r_state == ST_MAP) begin
            r_xi <= px[35:16];
            r_tx <= px[15:0];
            r_yi <= py[35:16];
            r_ty <= py[15:0];
            r_w  <= w_eff;
            r_h  <= h_eff;
        end
        if (r_state == ST_READ && r_cnt != 5'd0) begin
            r_pix[4'(r_cnt - 5'd1)] <= ram_rdata;
        end
        if (r_state == ST_FIT && r_step == 3'd4) begin
            if (r_fit == 3'd4) begin
                r_final <= fit_res;
            end else begin
                r_curve[r_fit[1:0]] <= fit_res;
            end
        end
    end

    // Saturate into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_final > OUT_MAX) begin
                r_out_value <= OUT_MAX[17:0];
                r_out_clip  <= 1'b1;
            end else if (r_final < OUT_MIN) begin
                r_out_value <= OUT_MIN[17:0];
                r_out_clip  <= 1'b1;
            end else begin
                r_out_value <= r_final[17:0];
                r_out_clip  <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_height_value = r_out_value;
    assign o_clipped      = r_out_clip;

    `BIR_ASSERT_NEXT(a_compute_maps, in_acc && i_kind, r_state == ST_MAP, "compute not mapped")
    `BIR_ASSERT_NEXT(a_result_holds, r_out_valid && !i_ready, r_out_valid, "result dropped")
    `BIR_ASSERT_NEXT(a_result_loads, out_load, r_out_valid, "result not loaded")
    `BIR_ASSERT_SAME(a_fit_in_fit, fit_ctl.en, r_state == ST_FIT, "fit outside fit state")

endmodule
